// ----- hdl/whdp_pkg.sv -----
// Package: shared constants, status codes and the job type of the WAV duration parser.
`timescale 1ns / 1ps
package whdp_pkg;

  // Chunk tags as they appear in a little-endian 32-bit word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Smallest fmt chunk body that carries rate and block align.
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TAG   = 3'd1;
  localparam logic [2:0] ST_FMT_SHORT = 3'd2;
  localparam logic [2:0] ST_NO_DATA   = 3'd3;
  localparam logic [2:0] ST_NO_FMT    = 3'd4;

  // Default number of finished files that may wait for the divider.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // One parsed file handed from the parser to the divider.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_length;
    logic [15:0] frame_bytes;
    logic [31:0] samp_rate;
  } job_t;

  // Write side of the job queue.
  typedef struct packed {
    logic push;
    job_t job;
  } job_push_t;

endpackage

// ----- hdl/whdp_if.sv -----
// Interfaces: byte input channel and duration result channel.
`timescale 1ns / 1ps
interface whdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface whdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds;
  logic [2:0]  status;

  modport source (output valid, output seconds, output status, input ready);
  modport sink (input valid, input seconds, input status, output ready);
endinterface

// ----- hdl/whdp_front.sv -----
// Front part: walks RIFF chunks a byte per cycle unless queue_full; queues a job per file.
`timescale 1ns / 1ps
module whdp_front
  import whdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  whdp_in_if.sink    byte_in,
  input  logic       queue_full,
  output job_push_t  job_wr
);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_CHDR = 3'd1;
  localparam logic [2:0] PH_FMT  = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_PAD  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [3:0]  count, count_next;
  logic [63:0] shift, shift_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] samp_rate, samp_rate_next;
  logic [15:0] frame_bytes, frame_bytes_next;
  logic [31:0] data_length, data_length_next;
  logic        fmt_seen, fmt_seen_next;
  logic [2:0]  parse_status, parse_status_next;

  logic [63:0] shifted;
  logic [3:0]  count_inc;
  logic        fire;
  logic [2:0]  job_status;

  assign byte_in.ready = !queue_full;
  assign fire          = byte_in.valid && byte_in.ready;
  assign shifted       = {byte_in.data_byte, shift[63:8]};
  assign count_inc     = count + 4'd1;

  // Parser next state for the byte on the port.
  always_comb begin
    phase_next        = phase;
    count_next        = count;
    shift_next        = shift;
    remaining_next    = remaining;
    samp_rate_next    = samp_rate;
    frame_bytes_next  = frame_bytes;
    data_length_next  = data_length;
    fmt_seen_next     = fmt_seen;
    parse_status_next = parse_status;
    case (phase)
      PH_RIFF: begin
        shift_next = shifted;
        count_next = count_inc;
        if (count_inc == 4'd4 && shifted[63:32] != TAG_RIFF) begin
          parse_status_next = ST_BAD_TAG;
          phase_next        = PH_ERR;
        end else if (count_inc == 4'd12) begin
          if (shifted[63:32] != TAG_WAVE) begin
            parse_status_next = ST_BAD_TAG;
            phase_next        = PH_ERR;
          end else begin
            count_next = 4'd0;
            phase_next = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        shift_next = shifted;
        count_next = count_inc;
        if (count_inc == 4'd8) begin
          count_next = 4'd0;
          if (shifted[31:0] == TAG_FMT) begin
            if (shifted[63:32] < FMT_MIN_SIZE) begin
              parse_status_next = ST_FMT_SHORT;
              phase_next        = PH_ERR;
            end else begin
              remaining_next = shifted[63:32] - FMT_MIN_SIZE;
              phase_next     = PH_FMT;
            end
          end else if (shifted[31:0] == TAG_DATA) begin
            data_length_next = shifted[63:32];
            phase_next       = PH_DONE;
          end else begin
            remaining_next = shifted[63:32];
            // An empty chunk has no body and no pad byte.
            phase_next = (shifted[63:32] == 32'd0) ? PH_CHDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (count[3:2] == 2'b01) begin
          samp_rate_next[{count[1:0], 3'b000} +: 8] = byte_in.data_byte;
        end else if (count == 4'd12) begin
          frame_bytes_next[7:0] = byte_in.data_byte;
        end else if (count == 4'd13) begin
          frame_bytes_next[15:8] = byte_in.data_byte;
        end
        count_next = count_inc;
        if (count == 4'd15) begin
          fmt_seen_next = 1'b1;
          if (remaining != 32'd0) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = shift[32] ? PH_PAD : PH_CHDR;
          end
        end
      end
      PH_SKIP: begin
        remaining_next = remaining - 32'd1;
        if (remaining == 32'd1) begin
          phase_next = shift[32] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_next = PH_CHDR;
      end
      default: begin
      end
    endcase
  end

  // Status of a file that ends with this byte.
  always_comb begin
    if (parse_status_next != ST_OK) begin
      job_status = parse_status_next;
    end else if (phase_next == PH_RIFF) begin
      job_status = ST_BAD_TAG;
    end else if (phase_next != PH_DONE) begin
      job_status = ST_NO_DATA;
    end else if (!fmt_seen_next) begin
      job_status = ST_NO_FMT;
    end else begin
      job_status = ST_OK;
    end
  end

  assign job_wr.push             = fire && byte_in.last_byte;
  assign job_wr.job.status       = job_status;
  assign job_wr.job.data_length  = data_length_next;
  assign job_wr.job.frame_bytes  = frame_bytes_next;
  assign job_wr.job.samp_rate    = samp_rate_next;

  // Parser registers; the last byte of a file returns them to the start.
  always_ff @(posedge clk) begin
    if (rst || (fire && byte_in.last_byte)) begin
      phase        <= PH_RIFF;
      count        <= 4'd0;
      shift        <= 64'd0;
      remaining    <= 32'd0;
      samp_rate    <= 32'd0;
      frame_bytes  <= 16'd0;
      data_length  <= 32'd0;
      fmt_seen     <= 1'b0;
      parse_status <= ST_OK;
    end else if (fire) begin
      phase        <= phase_next;
      count        <= count_next;
      shift        <= shift_next;
      remaining    <= remaining_next;
      samp_rate    <= samp_rate_next;
      frame_bytes  <= frame_bytes_next;
      data_length  <= data_length_next;
      fmt_seen     <= fmt_seen_next;
      parse_status <= parse_status_next;
    end
  end

endmodule

// ----- hdl/whdp_queue.sv -----
// Job queue: a short first-in first-out buffer between the parser and the divider.
`timescale 1ns / 1ps
module whdp_queue
  import whdp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  job_push_t job_wr,
  output logic      full,
  output logic      avail,
  output job_t      head,
  input  logic      pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  job_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full    = (fill == DepthCnt);
  assign avail   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = job_wr.push && !full;
  assign do_pop  = pop && avail;

  // Storage for queued jobs.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= job_wr.job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

  // The parser never pushes into a full queue, and the divider never pops an empty one.
  assert property (@(posedge clk) disable iff (rst) !(job_wr.push && full))
    else $error("Job pushed into a full queue.");
  assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("Job popped from an empty queue.");
  // The fill level never passes the depth.
  assert property (@(posedge clk) disable iff (rst) fill <= DepthCnt)
    else $error("Queue fill level beyond its depth.");

endmodule

// ----- hdl/whdp_back.sv -----
// Back part: two bit-serial divisions per valid file and the registered result.
`timescale 1ns / 1ps
module whdp_back
  import whdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  job_t        head,
  output logic        pop,
  whdp_out_if.source  result_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV1 = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state;
  logic [4:0]  step;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic [31:0] rate;
  logic [2:0]  job_status;
  logic        out_valid;
  logic [31:0] out_duration;
  logic [2:0]  out_status;

  logic [32:0] trial;
  logic        q_bit;
  logic [31:0] rem_step;
  logic        out_free;

  // One restoring division step: shift in the next dividend bit and try to subtract.
  assign trial    = {rem, quo[31]};
  assign q_bit    = (trial >= {1'b0, divisor});
  assign rem_step = q_bit ? 32'(trial - {1'b0, divisor}) : trial[31:0];

  assign out_free = !out_valid || result_out.ready;
  assign pop      = (state == S_IDLE) && avail;

  // Division sequencer: samples per channel first, then seconds.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 5'd0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= 5'd0;
          if (avail) begin
            job_status <= head.status;
            rem        <= 32'd0;
            divisor    <= {16'd0, head.frame_bytes};
            rate       <= head.samp_rate;
            if (head.status != ST_OK || head.samp_rate == 32'd0 ||
                head.frame_bytes == 16'd0) begin
              quo   <= 32'd0;
              state <= S_DONE;
            end else begin
              quo   <= head.data_length;
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          quo  <= {quo[30:0], q_bit};
          step <= step + 5'd1;
          if (step == 5'd31) begin
            rem     <= 32'd0;
            divisor <= rate;
            state   <= S_DIV2;
          end else begin
            rem <= rem_step;
          end
        end
        S_DIV2: begin
          quo  <= {quo[30:0], q_bit};
          rem  <= rem_step;
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid    <= 1'b1;
      out_duration <= quo;
      out_status   <= job_status;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.seconds = out_duration;
  assign result_out.status  = out_status;

  // A failed file always reports zero seconds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_duration == 32'd0))
    else $error("Non-zero duration with an error status.");
  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status <= ST_NO_FMT))
    else $error("Undefined status code on the output.");
  // The step counter is back at zero whenever a division starts.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && avail) |=> (step == 5'd0))
    else $error("Division started with a stale step count.");
  // Only successful files go through the divider.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 || state == S_DIV2) |-> (job_status == ST_OK && divisor != 32'd0))
    else $error("Divider running on a failed file or a zero divisor.");

endmodule

// ----- hdl/wav_header_duration_parser_top.sv -----
// Result path: the last byte queues a job; the idle divider pops it and, unless the file
// failed or a divisor is zero, runs two 32-step bit-serial divisions, then loads the
// result register once it is free. Flow: one byte per cycle while the queue is not full;
// one file at a time is divided; QUEUE_DEPTH finished files queue before byte input stalls.
// Reset: synchronous, active high; it clears the parser, the queue and the divider at once.
// Top level: RIFF/WAVE header parser that reports playing time in whole seconds.
`timescale 1ns / 1ps
module wav_header_duration_parser_top
  import whdp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  whdp_in_if.sink    byte_in,
  whdp_out_if.source result_out
);

  job_push_t job_wr;
  logic      queue_full;
  logic      queue_avail;
  job_t      queue_head;
  logic      queue_pop;

  // Byte parser.
  whdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .queue_full (queue_full),
    .job_wr     (job_wr)
  );

  // Jobs waiting for the divider.
  whdp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .job_wr (job_wr),
    .full   (queue_full),
    .avail  (queue_avail),
    .head   (queue_head),
    .pop    (queue_pop)
  );

  // Divider and result register.
  whdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (queue_avail),
    .head       (queue_head),
    .pop        (queue_pop),
    .result_out (result_out)
  );

endmodule

// ----- tb/sv/wav_header_duration_parser_top_tb.sv -----
// Testbench: byte-stream stimulus, duration prediction and result checking for the WAV parser.
`timescale 1ns / 1ps
module wav_header_duration_parser_top_tb
  import whdp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_BYTES = 500;
  localparam int RANDOM_FILES = 8;
  localparam int MAX_REPORTS  = 10;

  // Tags used only by the stimulus: a common list chunk and two near misses.
  localparam logic [31:0] TAG_LIST     = 32'h5453_494C;
  localparam logic [31:0] TAG_RIFX     = 32'h5846_4952;
  localparam logic [31:0] TAG_WAVA     = 32'h4156_4157;

  typedef enum logic [2:0] {
    PH_RIFF, PH_CHUNK_HDR, PH_FMT_BODY, PH_SKIP, PH_PAD, PH_DONE, PH_ERR
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       hold;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [2:0]  status;
  } duration_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  whdp_in_if  byte_in();
  whdp_out_if result_out();

  wav_header_duration_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .result_out(result_out)
  );

  always #5 clk = ~clk;

  // Parser state as the predictor tracks it.
  parse_phase_e phase       = PH_RIFF;
  logic [3:0]   hdr_count   = '0;
  logic [63:0]  hdr_shift   = '0;
  logic [31:0]  skip_left   = '0;
  logic [31:0]  samp_rate   = '0;
  logic [15:0]  frame_bytes = '0;
  logic [31:0]  data_len    = '0;
  logic         fmt_seen    = 1'b0;
  logic [2:0]   stop_code   = ST_OK;

  byte_item_t       pending_bytes[$];
  logic [7:0]       file_buf[$];
  duration_result_t expected_durations[$];

  int bytes_queued    = 0;
  int files_queued    = 0;
  int bytes_taken     = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int cycle_count     = 0;
  int status_seen[5]  = '{default: 0};

  logic byte_fire = 1'b0;
  logic res_fire  = 1'b0;

  // Feeds one byte to the predicted parser; returns 1 with the result on the last byte.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output duration_result_t res);
    logic [31:0] chunk_tag;
    logic [31:0] body_size;
    res.seconds = '0;
    res.status  = ST_OK;
    case (phase)
      PH_RIFF: begin
        hdr_shift = {b, hdr_shift[63:8]};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == 4'd4 && hdr_shift[63:32] != TAG_RIFF) begin
          stop_code = ST_BAD_TAG;
          phase = PH_ERR;
        end else if (hdr_count == 4'd12) begin
          if (hdr_shift[63:32] != TAG_WAVE) begin
            stop_code = ST_BAD_TAG;
            phase = PH_ERR;
          end else begin
            hdr_count = '0;
            phase = PH_CHUNK_HDR;
          end
        end
      end
      PH_CHUNK_HDR: begin
        hdr_shift = {b, hdr_shift[63:8]};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == 4'd8) begin
          chunk_tag = hdr_shift[31:0];
          body_size = hdr_shift[63:32];
          hdr_count = '0;
          if (chunk_tag == TAG_FMT) begin
            if (body_size < FMT_MIN_SIZE) begin
              stop_code = ST_FMT_SHORT;
              phase = PH_ERR;
            end else begin
              skip_left = body_size - FMT_MIN_SIZE;
              phase = PH_FMT_BODY;
            end
          end else if (chunk_tag == TAG_DATA) begin
            data_len = body_size;
            phase = PH_DONE;
          end else begin
            skip_left = body_size;
            if (body_size != 0) phase = PH_SKIP;
            else if (hdr_shift[32]) phase = PH_PAD;
            else phase = PH_CHUNK_HDR;
          end
        end
      end
      PH_FMT_BODY: begin
        // The chunk size stays in the upper word of the shift register during the body.
        if (hdr_count >= 4'd4 && hdr_count <= 4'd7)
          samp_rate[8 * (int'(hdr_count) - 4) +: 8] = b;
        else if (hdr_count == 4'd12)
          frame_bytes[7:0] = b;
        else if (hdr_count == 4'd13)
          frame_bytes[15:8] = b;
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == 4'd0) begin
          fmt_seen = 1'b1;
          if (skip_left != 0) phase = PH_SKIP;
          else if (hdr_shift[32]) phase = PH_PAD;
          else phase = PH_CHUNK_HDR;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          if (hdr_shift[32]) phase = PH_PAD;
          else phase = PH_CHUNK_HDR;
        end
      end
      PH_PAD: phase = PH_CHUNK_HDR;
      default: ;
    endcase
    if (!last) return 1'b0;

    if (stop_code != ST_OK) res.status = stop_code;
    else if (phase == PH_RIFF) res.status = ST_BAD_TAG;
    else if (phase != PH_DONE) res.status = ST_NO_DATA;
    else if (!fmt_seen) res.status = ST_NO_FMT;
    else if (samp_rate != 0 && frame_bytes != 0)
      res.seconds = (data_len / frame_bytes) / samp_rate;

    // The last byte leaves the parser ready for a new file.
    phase       = PH_RIFF;
    hdr_count   = '0;
    hdr_shift   = '0;
    skip_left   = '0;
    samp_rate   = '0;
    frame_bytes = '0;
    data_len    = '0;
    fmt_seen    = 1'b0;
    stop_code   = ST_OK;
    return 1'b1;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function automatic logic [31:0] random_tag();
    logic [31:0] t;
    do t = $urandom; while (t == TAG_FMT || t == TAG_DATA);
    return t;
  endfunction

  // File assembly helpers: bytes go into file_buf, then the file is queued whole.
  task automatic put_byte(input logic [7:0] v);
    file_buf.push_back(v);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.push_back(w[8 * i +: 8]);
  endtask

  task automatic put_riff_header();
    put_word(TAG_RIFF);
    put_word($urandom);
    put_word(TAG_WAVE);
  endtask

  task automatic put_fmt(input logic [31:0] size, input logic [31:0] rate,
                         input logic [15:0] align);
    put_word(TAG_FMT);
    put_word(size);
    put_word($urandom);
    put_word(rate);
    put_word($urandom);
    put_byte(align[7:0]);
    put_byte(align[15:8]);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    repeat (size - 16) put_byte(8'($urandom));
    if (size[0]) put_byte(8'($urandom));
  endtask

  task automatic put_skip_chunk(input logic [31:0] tag, input logic [31:0] size);
    put_word(tag);
    put_word(size);
    repeat (size) put_byte(8'($urandom));
    if (size[0]) put_byte(8'($urandom));
  endtask

  task automatic commit_file(input bit hold_first);
    byte_item_t it;
    foreach (file_buf[i]) begin
      it.b    = file_buf[i];
      it.last = (i == file_buf.size() - 1);
      it.hold = hold_first && (i == 0);
      pending_bytes.push_back(it);
    end
    bytes_queued += file_buf.size();
    files_queued++;
    file_buf.delete();
  endtask

  // Stimulus, end of run and verdict.
  initial begin
    int start_bytes;
    int start_files;
    int kind;
    int cut;
    logic [31:0] rate;
    logic [15:0] align;
    logic [31:0] length;

    byte_in.valid     = 1'b0;
    byte_in.data_byte = '0;
    byte_in.last_byte = 1'b0;
    result_out.ready  = 1'b0;

    // Single-byte files with the extreme byte values.
    put_byte(8'h00);
    commit_file(1'b0);
    put_byte(8'hFF);
    commit_file(1'b0);
    // Longest playing time: rate and block align of one, largest data size.
    put_riff_header();
    put_fmt(32'd16, 32'd1, 16'd1);
    put_word(TAG_DATA);
    put_word(32'hFFFF_FFFF);
    commit_file(1'b0);
    // The sender holds this file back until the results above have come.
    put_riff_header();
    put_fmt(32'd16, 32'd44100, 16'd4);
    put_word(TAG_DATA);
    put_word(32'd1_764_000);
    commit_file(1'b1);
    // Zero sample rate, then zero block align, then both at their largest.
    put_riff_header();
    put_fmt(32'd16, 32'd0, 16'd4);
    put_word(TAG_DATA);
    put_word(32'd1000);
    commit_file(1'b0);
    put_riff_header();
    put_fmt(32'd16, 32'd8000, 16'd0);
    put_word(TAG_DATA);
    put_word(32'd64000);
    commit_file(1'b0);
    put_riff_header();
    put_fmt(32'd16, 32'hFFFF_FFFF, 16'hFFFF);
    put_word(TAG_DATA);
    put_word(32'hFFFF_FFFF);
    commit_file(1'b0);
    // Bad RIFF tag followed by a well-formed remainder that must be ignored.
    put_word(TAG_RIFX);
    put_word(32'd36);
    put_word(TAG_WAVE);
    put_fmt(32'd16, 32'd1, 16'd1);
    put_word(TAG_DATA);
    put_word(32'd100);
    commit_file(1'b0);
    // Bad form tag.
    put_word(TAG_RIFF);
    put_word(32'd0);
    put_word(TAG_WAVA);
    put_fmt(32'd16, 32'd1, 16'd1);
    commit_file(1'b0);
    // File that stops inside the twelve-byte header.
    put_word(TAG_RIFF);
    put_word(32'd100);
    commit_file(1'b0);
    // fmt chunk one byte too short.
    put_riff_header();
    put_skip_chunk(TAG_FMT, 32'd15);
    put_word(TAG_DATA);
    put_word(32'd8);
    commit_file(1'b0);
    // Data header with no fmt chunk in front of it.
    put_riff_header();
    put_skip_chunk(TAG_LIST, 32'd4);
    put_word(TAG_DATA);
    put_word(32'd800);
    commit_file(1'b0);
    // Odd fmt with pad, empty and odd unknown chunks, a later fmt that wins, trailing bytes.
    put_riff_header();
    put_fmt(32'd17, 32'd8000, 16'd1);
    put_skip_chunk(TAG_LIST, 32'd0);
    put_skip_chunk(random_tag(), 32'd3);
    put_fmt(32'd18, 32'd22050, 16'd2);
    put_word(TAG_DATA);
    put_word(32'd441_000);
    put_word(TAG_RIFF);
    commit_file(1'b0);
    // Files that end inside a huge fmt chunk and inside a huge unknown chunk.
    put_riff_header();
    put_word(TAG_FMT);
    put_word(32'hFFFF_FFFF);
    repeat (20) put_byte(8'($urandom));
    commit_file(1'b0);
    put_riff_header();
    put_word(random_tag());
    put_word(32'hFFFF_FFFF);
    repeat (5) put_byte(8'($urandom));
    commit_file(1'b0);
    // File that ends inside the data chunk header.
    put_riff_header();
    put_fmt(32'd16, 32'd8000, 16'd2);
    put_word(TAG_DATA);
    put_byte(8'h10);
    commit_file(1'b0);

    // Random files: mostly well formed with random content, some broken on purpose.
    start_bytes = bytes_queued;
    start_files = files_queued;
    while (bytes_queued - start_bytes < RANDOM_BYTES ||
           files_queued - start_files < RANDOM_FILES) begin
      kind = $urandom_range(0, 99);
      put_riff_header();
      repeat ($urandom_range(0, 2)) put_skip_chunk(random_tag(), $urandom_range(0, 7));
      if (kind >= 8) begin
        repeat ((kind % 7 == 0) ? 2 : 1) begin
          case ($urandom_range(0, 7))
            0:       rate = 32'd8000;
            1:       rate = 32'd44100;
            2:       rate = 32'd48000;
            3, 4:    rate = $urandom_range(1, 64);
            5, 6:    rate = $urandom;
            default: rate = '0;
          endcase
          case ($urandom_range(0, 7))
            0:       align = 16'd1;
            1:       align = 16'd2;
            2:       align = 16'd4;
            3, 4:    align = 16'($urandom_range(1, 8));
            5, 6:    align = 16'($urandom);
            default: align = '0;
          endcase
          put_fmt(32'd16 + $urandom_range(0, 5), rate, align);
        end
      end
      if (kind >= 92) begin
        put_word(TAG_FMT);
        put_word($urandom_range(0, 15));
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) put_skip_chunk(random_tag(), $urandom_range(0, 9));
      case ($urandom_range(0, 3))
        0:       length = $urandom_range(0, 255);
        1:       length = $urandom_range(0, 2_000_000);
        default: length = $urandom;
      endcase
      put_word(TAG_DATA);
      put_word(length);
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
      if (kind >= 80 && kind < 86) begin
        cut = $urandom_range(1, file_buf.size() - 1);
        while (file_buf.size() > cut) void'(file_buf.pop_back());
      end else if (kind >= 86 && kind < 92) begin
        cut = $urandom_range(0, file_buf.size() - 1);
        file_buf[cut] = file_buf[cut] ^ 8'($urandom_range(1, 255));
      end
      commit_file($urandom_range(0, 11) == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (bytes_taken == bytes_queued);
    wait (expected_durations.size() == 0);
    repeat (80) @(posedge clk);

    fail_count += expected_durations.size();
    $display("Sent %0d files in %0d bytes and checked %0d durations.",
             files_queued, bytes_queued, results_checked);
    $display("Statuses: ok %0d, bad tag %0d, short fmt %0d, no data %0d, no fmt %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_TAG], status_seen[ST_FMT_SHORT],
             status_seen[ST_NO_DATA], status_seen[ST_NO_FMT]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Byte driver: one item per handshake, with a drawn wait before each item.
  always @(negedge clk) begin : byte_driver
    bit         holding;
    byte_item_t item;
    static int  gap_left = 0;
    static int  bytes_sent = 0;
    static bit  calm = 1'b0;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else begin
      holding = byte_in.valid && !byte_fire;
      if (byte_fire) begin
        bytes_sent++;
        if (bytes_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        gap_left = calm ? 0 : $urandom_range(0, 13);
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].hold && expected_durations.size() != 0)) begin
          item = pending_bytes.pop_front();
          byte_in.data_byte <= item.b;
          byte_in.last_byte <= item.last;
          holding = 1'b1;
        end
      end
      byte_in.valid <= holding;
    end
  end

  // Result sink: ready drops for a drawn number of cycles after each result.
  always @(negedge clk) begin : result_sink
    static int stall_left = 0;
    static int taken = 0;
    static bit calm = 1'b0;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (res_fire) begin
        taken++;
        if (taken % 6 == 0) calm = ($urandom_range(0, 2) == 0);
        stall_left = calm ? 0 : $urandom_range(0, 13);
      end
      if (stall_left != 0) begin
        stall_left--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted byte and checks every accepted result.
  always @(posedge clk) begin : monitor
    duration_result_t res;
    duration_result_t want;
    if (rst) begin
      byte_fire <= 1'b0;
      res_fire  <= 1'b0;
    end else begin
      byte_fire <= byte_in.valid && byte_in.ready;
      res_fire  <= result_out.valid && result_out.ready;
      if (byte_in.valid && byte_in.ready) begin
        bytes_taken++;
        if (parse_byte(byte_in.data_byte, byte_in.last_byte, res))
          expected_durations.push_back(res);
      end
      if (result_out.valid && result_out.ready) begin
        if (expected_durations.size() == 0) begin
          flag_mismatch("result with none expected", 32'd0, result_out.seconds);
        end else begin
          want = expected_durations.pop_front();
          results_checked++;
          if (want.status <= ST_NO_FMT) status_seen[want.status]++;
          if (result_out.seconds !== want.seconds)
            flag_mismatch("seconds", want.seconds, result_out.seconds);
          if (result_out.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(result_out.status));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d durations outstanding.",
               cycle_count, expected_durations.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ----- wav_header_duration_parser_top.f -----
hdl/whdp_pkg.sv
hdl/whdp_if.sv
hdl/whdp_front.sv
hdl/whdp_queue.sv
hdl/whdp_back.sv
hdl/wav_header_duration_parser_top.sv
tb/sv/wav_header_duration_parser_top_tb.sv
